/* hdl/slt_pkg.sv */
package slt_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned OP_W  = 2;
  localparam int unsigned ST_W  = 3;
  localparam int unsigned POS_W = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  typedef enum logic [ST_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_DELETED   = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_CMP,
    CMD_INS,
    CMD_DEL
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t               cmd;
    logic signed [KEY_W-1:0] key;
  } cell_ctl_t;

endpackage

/* hdl/slt_cell.sv */
module slt_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  slt_pkg::cell_ctl_t                ctl,
  input  logic signed [slt_pkg::KEY_W-1:0]  left_value,
  input  logic                              left_valid,
  input  logic                              left_le,
  input  logic                              left_lt,
  input  logic signed [slt_pkg::KEY_W-1:0]  right_value,
  input  logic                              right_valid,
  output logic signed [slt_pkg::KEY_W-1:0]  value,
  output logic                              valid,
  output logic                              le,
  output logic                              lt,
  output logic                              first
);

  assign first = le && !lt && left_lt;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctl.cmd)
        slt_pkg::CMD_INS: begin
          if (!le) begin
            if (left_le) begin
              value <= ctl.key;
              valid <= 1'b1;
            end else begin
              value <= left_value;
              valid <= left_valid;
            end
          end
        end
        slt_pkg::CMD_DEL: begin
          if (!lt) begin
            value <= right_value;
            valid <= right_valid;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmd == slt_pkg::CMD_CMP) begin
      le <= valid && (value <= ctl.key);
      lt <= valid && (value < ctl.key);
    end
  end

endmodule

/* hdl/sorted_list_table_core.sv */
// Ordered table of up to DEPTH signed 32-bit keys held in a row of cells, one key per
// cell, ascending. Each request word (op, value) gives one response word: insert places
// the key after any equal keys, search reports the 1-based position of the first equal
// key, delete removes it and the later keys close up. A request has three steps: accept;
// compare, in which every cell registers its order against the key; and update, in
// which, on insert or delete, cells shift by one toward or away from their neighbor and
// the response is loaded. The update waits while a previous response is still stalled;
// the next request is taken once the update has been made, so one request can sit in the
// output register while the next is compared. The table is empty after reset.
module sorted_list_table_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [slt_pkg::OP_W-1:0]          op,
  input  logic signed [slt_pkg::KEY_W-1:0]  value,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic [slt_pkg::ST_W-1:0]          status,
  output logic [slt_pkg::POS_W-1:0]         position,
  output logic [slt_pkg::POS_W-1:0]         entries_held
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  state_t                             state;
  logic [slt_pkg::OP_W-1:0]           op_reg;
  logic signed [slt_pkg::KEY_W-1:0]   key;
  logic [CNT_W-1:0]                   count;
  logic [CNT_W-1:0]                   count_next;
  slt_pkg::cell_ctl_t                 ctl;
  slt_pkg::status_t                   status_next;
  logic [slt_pkg::POS_W-1:0]          position_next;
  logic [IDX_W-1:0]                   first_idx;
  logic [IDX_W+slt_pkg::POS_W-1:0]    idx_ext;
  logic [CNT_W+slt_pkg::POS_W-1:0]    cnt_ext;
  logic                               found;
  logic                               upd_go;

  logic signed [slt_pkg::KEY_W-1:0]   cell_value [DEPTH];
  logic [DEPTH-1:0]                   cell_valid;
  logic [DEPTH-1:0]                   cell_le;
  logic [DEPTH-1:0]                   cell_lt;
  logic [DEPTH-1:0]                   cell_first;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [slt_pkg::KEY_W-1:0] lv;
      logic signed [slt_pkg::KEY_W-1:0] rv;
      logic                             lval;
      logic                             lle;
      logic                             llt;
      logic                             rval;
      if (g == 0) begin : g_head
        assign lv   = '0;
        assign lval = 1'b0;
        assign lle  = 1'b1;
        assign llt  = 1'b1;
      end else begin : g_mid
        assign lv   = cell_value[g-1];
        assign lval = cell_valid[g-1];
        assign lle  = cell_le[g-1];
        assign llt  = cell_lt[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
        assign rv   = '0;
        assign rval = 1'b0;
      end else begin : g_body
        assign rv   = cell_value[g+1];
        assign rval = cell_valid[g+1];
      end
      slt_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctl         (ctl),
        .left_value  (lv),
        .left_valid  (lval),
        .left_le     (lle),
        .left_lt     (llt),
        .right_value (rv),
        .right_valid (rval),
        .value       (cell_value[g]),
        .valid       (cell_valid[g]),
        .le          (cell_le[g]),
        .lt          (cell_lt[g]),
        .first       (cell_first[g])
      );
    end
  endgenerate

  always_comb begin
    first_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_first[i]) begin
        first_idx = first_idx | IDX_W'(i);
      end
    end
  end

  assign found   = |cell_first;
  assign idx_ext = {{slt_pkg::POS_W{1'b0}}, first_idx};
  assign upd_go  = (state == S_UPD) && !(rsp_valid && rsp_stall);
  assign req_stall = (state != S_IDLE);

  always_comb begin
    status_next   = slt_pkg::ST_NOT_FOUND;
    position_next = '0;
    count_next    = count;
    ctl.key       = key;
    ctl.cmd       = slt_pkg::CMD_HOLD;
    if (state == S_CMP) begin
      ctl.cmd = slt_pkg::CMD_CMP;
    end
    if (op_reg == slt_pkg::OP_INSERT) begin
      if (count == CNT_W'(DEPTH)) begin
        status_next = slt_pkg::ST_FULL;
      end else begin
        status_next = slt_pkg::ST_INSERTED;
        count_next  = count + 1'b1;
        if (upd_go) begin
          ctl.cmd = slt_pkg::CMD_INS;
        end
      end
    end else if (op_reg == slt_pkg::OP_SEARCH || op_reg == slt_pkg::OP_DELETE) begin
      if (count == '0) begin
        status_next = slt_pkg::ST_EMPTY;
      end else if (!found) begin
        status_next = slt_pkg::ST_NOT_FOUND;
      end else begin
        position_next = idx_ext[slt_pkg::POS_W-1:0] + 1'b1;
        if (op_reg == slt_pkg::OP_SEARCH) begin
          status_next = slt_pkg::ST_FOUND;
        end else begin
          status_next = slt_pkg::ST_DELETED;
          count_next  = count - 1'b1;
          if (upd_go) begin
            ctl.cmd = slt_pkg::CMD_DEL;
          end
        end
      end
    end
  end

  assign cnt_ext = {{slt_pkg::POS_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && !upd_go) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_reg <= op;
            key    <= value;
            state  <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (upd_go) begin
            count        <= count_next;
            status       <= status_next;
            position     <= position_next;
            entries_held <= cnt_ext[slt_pkg::POS_W-1:0];
            rsp_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
